FILE: src/ctok_pkg.sv
// shared types and constants of the c source tokenizer
// byte class codes, result kind and error codes, result record
// no dependencies
package ctok_pkg;

  localparam int CH_W      = 8;
  localparam int KIND_W    = 4;
  localparam int ERR_W     = 2;
  localparam int LINE_W    = 16;
  localparam int COL_W     = 10;
  localparam int LEN_W     = 11;

  // byte classes, decided in the front part
  localparam int CLS_W = 4;
  typedef logic [CLS_W-1:0] cls_t;
  localparam cls_t CLS_NUL    = 4'd0;
  localparam cls_t CLS_CR     = 4'd1;
  localparam cls_t CLS_LF     = 4'd2;
  localparam cls_t CLS_BLANK  = 4'd3;
  localparam cls_t CLS_ALPHA  = 4'd4;
  localparam cls_t CLS_DIGIT  = 4'd5;
  localparam cls_t CLS_SYM    = 4'd6;
  localparam cls_t CLS_HASH   = 4'd7;
  localparam cls_t CLS_DQUOTE = 4'd8;
  localparam cls_t CLS_SQUOTE = 4'd9;
  localparam cls_t CLS_OTHER  = 4'd10;

  // token kinds
  localparam logic [KIND_W-1:0] K_BLANK   = 4'd0;
  localparam logic [KIND_W-1:0] K_WORD    = 4'd1;
  localparam logic [KIND_W-1:0] K_NUMBER  = 4'd2;
  localparam logic [KIND_W-1:0] K_SYMBOLS = 4'd3;
  localparam logic [KIND_W-1:0] K_STRING  = 4'd4;
  localparam logic [KIND_W-1:0] K_CHAR    = 4'd5;
  localparam logic [KIND_W-1:0] K_NEWLINE = 4'd6;
  localparam logic [KIND_W-1:0] K_END     = 4'd7;
  localparam logic [KIND_W-1:0] K_ERROR   = 4'd8;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] E_UNKNOWN  = 2'd1;
  localparam logic [ERR_W-1:0] E_QUOTE    = 2'd2;
  localparam logic [ERR_W-1:0] E_TOO_LONG = 2'd3;

  // result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef struct packed {
    logic valid;
    cls_t cls;
  } cls_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  error_code;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  start_column;
    logic [LEN_W-1:0]  token_length;
    logic              last;
  } result_t;

endpackage

FILE: src/ctok_front.sv
// front part: classifies each accepted byte and holds it in a two-entry queue
// feeding the back part; uses ctok_pkg
module ctok_front
  import ctok_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [CH_W-1:0] ch,
  output logic            full,
  output cls_item_t       item,
  input  logic            take
);

  cls_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cls_t       cls_in;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    if (ch == 8'd0) begin
      cls_in = CLS_NUL;
    end else if (ch == 8'd13) begin
      cls_in = CLS_CR;
    end else if (ch == 8'd10) begin
      cls_in = CLS_LF;
    end else if (ch == 8'd32 || ch == 8'd9) begin
      cls_in = CLS_BLANK;
    end else if ((ch >= 8'd97 && ch <= 8'd122) || (ch >= 8'd65 && ch <= 8'd90) ||
                 ch == 8'd95) begin
      cls_in = CLS_ALPHA;
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      cls_in = CLS_DIGIT;
    end else if (ch == 8'd35) begin
      cls_in = CLS_HASH;
    end else if (ch == 8'd34) begin
      cls_in = CLS_DQUOTE;
    end else if (ch == 8'd39) begin
      cls_in = CLS_SQUOTE;
    end else if ((ch >= 8'd33 && ch <= 8'd47) || (ch >= 8'd58 && ch <= 8'd64) ||
                 (ch >= 8'd91 && ch <= 8'd94) || ch == 8'd96 ||
                 (ch >= 8'd123 && ch <= 8'd126)) begin
      cls_in = CLS_SYM;
    end else begin
      cls_in = CLS_OTHER;
    end
  end

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = take && (count != 2'd0);
  assign item.valid = (count != 2'd0);
  assign item.cls   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: src/ctok_back.sv
// back part: token state machine and a four-entry result queue that takes
// up to two results per byte; uses ctok_pkg
module ctok_back
  import ctok_pkg::*;
#(
  parameter int MAX_LINE = 1024
)
(
  input  logic      clk,
  input  logic      rst,
  input  cls_item_t item,
  output logic      take,
  input  logic      pop,
  output result_t   head,
  output logic      empty
);

  localparam int CW = $clog2(MAX_LINE + 1);
  localparam logic [CW-1:0] MAX_COL = CW'(MAX_LINE);

  localparam logic [2:0] RK_IDLE  = 3'd0;
  localparam logic [2:0] RK_BLANK = 3'd1;
  localparam logic [2:0] RK_WORD  = 3'd2;
  localparam logic [2:0] RK_NUM   = 3'd3;
  localparam logic [2:0] RK_SYM   = 3'd4;
  localparam logic [2:0] RK_STR   = 3'd5;
  localparam logic [2:0] RK_CHR   = 3'd6;

  // token state
  logic [2:0]        run_kind;
  logic [CW-1:0]     run_start;
  logic [CW-1:0]     run_length;
  logic [CW-1:0]     column;
  logic [LINE_W-1:0] line_count;
  logic              after_cr;

  logic [2:0]        run_kind_next;
  logic [CW-1:0]     run_start_next;
  logic [CW-1:0]     run_length_next;
  logic [CW-1:0]     column_next;
  logic [LINE_W-1:0] line_count_next;
  logic              after_cr_next;

  // result queue
  result_t             rq [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;

  logic    is_run;
  logic    is_lit;
  logic    cont;
  logic    close_v;
  logic    tail_v;
  result_t close_res;
  result_t tail_res;
  result_t run_res;
  result_t here_res;
  result_t r0;
  result_t r1;
  logic [1:0] n;
  cls_t    c;
  logic    do_pop;

  assign c      = item.cls;
  assign take   = item.valid && (count <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign is_run = (run_kind >= RK_BLANK) && (run_kind <= RK_SYM);
  assign is_lit = (run_kind == RK_STR) || (run_kind == RK_CHR);

  always_comb begin
    case (run_kind)
      RK_BLANK: cont = (c == CLS_BLANK);
      RK_WORD:  cont = (c == CLS_ALPHA) || (c == CLS_DIGIT);
      RK_NUM:   cont = (c == CLS_DIGIT);
      RK_SYM:   cont = (c == CLS_SYM) || (c == CLS_HASH) ||
                       (c == CLS_DQUOTE) || (c == CLS_SQUOTE);
      default:  cont = 1'b0;
    endcase
  end

  always_comb begin
    run_res.kind         = KIND_W'(run_kind) - KIND_W'(1);
    run_res.error_code   = E_NONE;
    run_res.line_number  = line_count;
    run_res.start_column = COL_W'(run_start);
    run_res.token_length = LEN_W'(run_length);
    run_res.last         = 1'b0;
    here_res             = run_res;
    here_res.start_column = COL_W'(column);
    here_res.token_length = LEN_W'(1);
  end

  always_comb begin
    close_v         = 1'b0;
    close_res       = run_res;
    tail_v          = 1'b0;
    tail_res        = here_res;
    run_kind_next   = run_kind;
    run_start_next  = run_start;
    run_length_next = run_length;
    column_next     = column;
    line_count_next = line_count;
    after_cr_next   = 1'b0;
    if (c == CLS_NUL) begin
      // close anything open, report end, back to reset state
      close_v = is_run || is_lit;
      if (is_lit) begin
        close_res.kind       = K_ERROR;
        close_res.error_code = E_QUOTE;
      end
      tail_v                = 1'b1;
      tail_res.kind         = K_END;
      tail_res.token_length = '0;
      run_kind_next         = RK_IDLE;
      run_start_next        = '0;
      run_length_next       = '0;
      column_next           = '0;
      line_count_next       = '0;
    end else if ((c == CLS_CR) || (c == CLS_LF)) begin
      if (!((c == CLS_LF) && after_cr)) begin
        close_v = is_run || is_lit;
        if (is_lit) begin
          close_res.kind       = K_ERROR;
          close_res.error_code = E_QUOTE;
        end
        tail_v          = 1'b1;
        tail_res.kind   = K_NEWLINE;
        run_kind_next   = RK_IDLE;
        run_start_next  = '0;
        run_length_next = '0;
        column_next     = '0;
        if (line_count != '1) begin
          line_count_next = line_count + LINE_W'(1);
        end
        after_cr_next = (c == CLS_CR);
      end
    end else if (column >= MAX_COL) begin
      // over-long line: report an open run and a too-long error, drop an open literal
      close_v             = is_run;
      tail_v              = 1'b1;
      tail_res.kind       = K_ERROR;
      tail_res.error_code = E_TOO_LONG;
      run_kind_next       = RK_IDLE;
      run_start_next      = '0;
      run_length_next     = '0;
    end else if (is_lit) begin
      if (((run_kind == RK_STR) && (c == CLS_DQUOTE)) ||
          ((run_kind == RK_CHR) && (c == CLS_SQUOTE))) begin
        tail_v          = 1'b1;
        tail_res        = run_res;
        run_kind_next   = RK_IDLE;
        run_start_next  = '0;
        run_length_next = '0;
      end else begin
        run_length_next = run_length + CW'(1);
      end
      column_next = column + CW'(1);
    end else if (cont) begin
      run_length_next = run_length + CW'(1);
      column_next     = column + CW'(1);
    end else begin
      close_v         = is_run;
      run_start_next  = column;
      run_length_next = CW'(1);
      case (c)
        CLS_BLANK: run_kind_next = RK_BLANK;
        CLS_ALPHA: run_kind_next = RK_WORD;
        CLS_DIGIT: run_kind_next = RK_NUM;
        CLS_SYM:   run_kind_next = RK_SYM;
        CLS_DQUOTE, CLS_SQUOTE: begin
          run_kind_next   = (c == CLS_DQUOTE) ? RK_STR : RK_CHR;
          run_start_next  = column + CW'(1);
          run_length_next = '0;
        end
        default: begin
          // hash or unknown byte at token start
          run_kind_next       = RK_IDLE;
          run_start_next      = '0;
          run_length_next     = '0;
          tail_v              = 1'b1;
          tail_res.kind       = K_ERROR;
          tail_res.error_code = E_UNKNOWN;
        end
      endcase
      column_next = column + CW'(1);
    end
  end

  // pack up to two results in order, mark the final one
  always_comb begin
    n       = {1'b0, close_v} + {1'b0, tail_v};
    r0      = close_v ? close_res : tail_res;
    r0.last = (n == 2'd1);
    r1      = tail_res;
    r1.last = 1'b1;
  end

  assign do_pop = pop && (count != '0);
  assign empty  = (count == '0);
  assign head   = rq[rd_ptr];

  always_ff @(posedge clk) begin
    if (take) begin
      if (n != 2'd0) begin
        rq[wr_ptr] <= r0;
      end
      if (n == 2'd2) begin
        rq[wr_ptr + RQ_PTR_W'(1)] <= r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind   <= RK_IDLE;
      run_start  <= '0;
      run_length <= '0;
      column     <= '0;
      line_count <= '0;
      after_cr   <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (take) begin
        run_kind   <= run_kind_next;
        run_start  <= run_start_next;
        run_length <= run_length_next;
        column     <= column_next;
        line_count <= line_count_next;
        after_cr   <= after_cr_next;
        wr_ptr     <= wr_ptr + RQ_PTR_W'(n);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      count <= count + (take ? RQ_CNT_W'(n) : RQ_CNT_W'(0)) - RQ_CNT_W'(do_pop);
    end
  end

endmodule

FILE: src/c_source_tokenizer_core.sv
// top level of the c source tokenizer: front classifier and back token engine
// depends on ctok_pkg, ctok_front, ctok_back
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+------------------------------------
//   source    | in        | push / full        | ch
//   tokens    | out       | pop / empty        | kind, error_code, line_number,
//             |           |                    | start_column, token_length, last
//
// one byte per cycle sustained while the result queue has room; the token engine in the back part updates its
// state for one taken byte each cycle and writes zero, one or two results per byte
// results leave one per cycle, so bytes that close a run and open an error, newline or end
// (two results) are limited by the result port to one token per cycle
// a source byte is registered in the byte queue and then in the result queue before its first result shows
// rst is synchronous and clears all token state and both queues; no clearing pass
// stalls on pop back up through the result queue, the byte queue and then full
module c_source_tokenizer_core
  import ctok_pkg::*;
#(
  parameter int MAX_LINE = 1024
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CH_W-1:0]   ch,
  output logic              empty,
  input  logic              pop,
  output logic [KIND_W-1:0] kind,
  output logic [ERR_W-1:0]  error_code,
  output logic [LINE_W-1:0] line_number,
  output logic [COL_W-1:0]  start_column,
  output logic [LEN_W-1:0]  token_length,
  output logic              last
);

  // classified byte handed from front to back
  cls_item_t item;
  logic      take;
  result_t   head;

  ctok_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .ch   (ch),
    .full (full),
    .item (item),
    .take (take)
  );

  ctok_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .take  (take),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  // oldest waiting token on the result ports
  assign kind         = head.kind;
  assign error_code   = head.error_code;
  assign line_number  = head.line_number;
  assign start_column = head.start_column;
  assign token_length = head.token_length;
  assign last         = head.last;

endmodule

FILE: src/ctok_checker.sv
// port-level checks of the c source tokenizer, bound to the top level
// depends on ctok_pkg
module ctok_checker
  import ctok_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [KIND_W-1:0] kind,
  input logic [ERR_W-1:0]  error_code,
  input logic [LINE_W-1:0] line_number,
  input logic [COL_W-1:0]  start_column,
  input logic [LEN_W-1:0]  token_length,
  input logic              last
);

  // queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queues not drained after reset");

  // only error tokens carry an error code
  a_err_only_on_error: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != K_ERROR |-> error_code == E_NONE)
    else $error("error code on a non-error token");

  // newline tokens are one long and always close their byte's results
  a_newline_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == K_NEWLINE |-> token_length == LEN_W'(1) && last)
    else $error("malformed newline token");

  // end tokens are empty and final
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == K_END |-> token_length == '0 && last)
    else $error("malformed end token");

  // a waiting result that is not taken holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kind) && $stable(error_code) &&
    $stable(line_number) && $stable(start_column) && $stable(token_length) &&
    $stable(last))
    else $error("waiting result changed");

endmodule

bind c_source_tokenizer_core ctok_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .kind         (kind),
  .error_code   (error_code),
  .line_number  (line_number),
  .start_column (start_column),
  .token_length (token_length),
  .last         (last)
);
